// File: sv/audio_bin_peak_rms_meter_defines.svh
// Assertion macros used by the meter's top-level RTL.
`ifndef AUDIO_BIN_PEAK_RMS_METER_DEFINES_SVH
`define AUDIO_BIN_PEAK_RMS_METER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABPRM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABPRM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/abprm_pkg.sv
package abprm_pkg;

    // Configuration register
    localparam int SPB_W = 20;
    localparam logic [SPB_W-1:0] SPB_RESET = 20'd480;

    // APB port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic {
        REG_SAMPLES_PER_BIN = 1'b0
    } reg_index_t;

    // Result fields
    localparam int BIN_W = 24;
    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam int OUT_DATA_W = 40;

    // Widest square sum; larger sums saturate.
    localparam int SUM_MAX_W = 64;

    // RMS: q = floor(floor(4*255^2*sum / FS^2) / n), level = (isqrt(q)+1)/2.
    localparam int RMS_SCALE_W = 18;
    localparam logic [RMS_SCALE_W-1:0] RMS_SCALE = 18'd260100;
    localparam int QUO_W = 18;
    localparam int ROOT_W = 9;
    localparam int ROOT_STEP_W = 4;
    localparam int STEP_W = 5;

    // Bin close event from the accumulator to the level unit.
    typedef struct packed {
        logic valid;
        logic final_bin;
    } close_t;

    // One finished result.
    typedef struct packed {
        logic [BIN_W-1:0]   bin_number;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] rms_level;
        logic               final_bin;
    } result_t;

endpackage

// File: sv/audio_bin_peak_rms_meter.sv
// Samples are taken one at a time: each passes the bit-serial squarer, then an update step,
// before the next is accepted. At a bin end the level unit runs multiply, divide, square root
// and hand-off, and takes no sample until its result is loaded into the output register.
// Reset (aresetn low, synchronous) clears the sums, counts and bin number and sets
// samples_per_bin to 480.
`include "audio_bin_peak_rms_meter_defines.svh"

module audio_bin_peak_rms_meter #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Sample channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: sample_value, then zero padding to whole bytes
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    // s_tlast: end_of_stream
    input  logic                                s_tlast,
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: bin_number [23:0], peak_level [31:24], rms_level [39:32]
    output logic [abprm_pkg::OUT_DATA_W-1:0]    m_tdata,
    // m_tlast: final_bin
    output logic                                m_tlast,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [abprm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [abprm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [abprm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import abprm_pkg::*;

    localparam int SUM_FULL_W = 2 * SAMPLE_BITS + COUNT_BITS - 1;
    localparam int SUM_W      = (SUM_FULL_W > SUM_MAX_W) ? SUM_MAX_W : SUM_FULL_W;

    logic [SPB_W-1:0]      spb_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    logic                   s_accept;
    logic                   cfg_write;
    logic                   reg_hit;
    logic                   acc_busy;
    close_t                 close;
    logic [SUM_W-1:0]       bin_sum;
    logic [COUNT_BITS-1:0]  bin_count;
    logic [SAMPLE_BITS-1:0] bin_peak;
    logic [BIN_W-1:0]       bin_index;
    logic                   lvl_busy;
    logic                   lvl_done;
    logic                   lvl_take;
    result_t                lvl_res;

    // Configuration register access.
    assign pready    = 1'b1;
    assign reg_hit   = (reg_index_t'(paddr[APB_ADDR_W-1]) == REG_SAMPLES_PER_BIN);
    assign cfg_write = psel && penable && pwrite && pready && reg_hit;
    assign prdata    = reg_hit ? APB_DATA_W'(spb_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spb_reg <= SPB_RESET;
        end else if (cfg_write) begin
            spb_reg <= pwdata[SPB_W-1:0];
        end
    end

    // One sample at a time; the level unit must be free before a bin can close.
    assign s_tready = !acc_busy && !lvl_busy && !close.valid;
    assign s_accept = s_tvalid && s_tready;

    abprm_acc #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .SUM_W       (SUM_W)
    ) u_acc (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (s_accept),
        .sample          (s_tdata[SAMPLE_BITS-1:0]),
        .eos             (s_tlast),
        .samples_per_bin (spb_reg),
        .busy            (acc_busy),
        .close           (close),
        .bin_sum         (bin_sum),
        .bin_count       (bin_count),
        .bin_peak        (bin_peak),
        .bin_index       (bin_index)
    );

    abprm_lvl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .SUM_W       (SUM_W)
    ) u_lvl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .close     (close),
        .bin_sum   (bin_sum),
        .bin_count (bin_count),
        .bin_peak  (bin_peak),
        .bin_index (bin_index),
        .take      (lvl_take),
        .busy      (lvl_busy),
        .done      (lvl_done),
        .result    (lvl_res)
    );

    // Output register: loads a finished result when empty or being drained.
    assign lvl_take = lvl_done && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (lvl_take) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {lvl_res.rms_level, lvl_res.peak_level, lvl_res.bin_number};
                m_tlast_reg  <= lvl_res.final_bin;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `ABPRM_ASSERT_IMP(a_close_lvl_free, aclk, aresetn, close.valid, !lvl_busy, "bin closed while level unit busy")
    `ABPRM_ASSERT_NXT(a_close_starts, aclk, aresetn, close.valid, lvl_busy, "level unit did not start on bin close")
    `ABPRM_ASSERT_NXT(a_one_sample, aclk, aresetn, s_accept, !s_tready, "sample transfer not followed by busy")
    `ABPRM_ASSERT_NXT(a_result_load, aclk, aresetn, lvl_take, m_tvalid && (m_tlast == $past(lvl_res.final_bin)), "result not loaded into output register")

endmodule

// File: sv/abprm_acc.sv
module abprm_acc #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20,
    parameter int SUM_W       = 51
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [SAMPLE_BITS-1:0]         sample,
    input  logic                           eos,
    input  logic [abprm_pkg::SPB_W-1:0]    samples_per_bin,
    output logic                           busy,
    output abprm_pkg::close_t              close,
    output logic [SUM_W-1:0]               bin_sum,
    output logic [COUNT_BITS-1:0]          bin_count,
    output logic [SAMPLE_BITS-1:0]         bin_peak,
    output logic [abprm_pkg::BIN_W-1:0]    bin_index
);
    import abprm_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int CNT_W  = $clog2(SAMPLE_BITS);
    localparam int CMP_W  = (COUNT_BITS > SPB_W) ? COUNT_BITS : SPB_W;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SAMPLE_BITS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        A_IDLE,
        A_SQUARE,
        A_UPDATE
    } acc_state_t;

    acc_state_t             state_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SAMPLE_BITS-1:0] mplr_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [CNT_W-1:0]       step_reg;
    logic                   eos_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [BIN_W-1:0]       bin_reg;
    close_t                 close_reg;
    logic [SUM_W-1:0]       snap_sum_reg;
    logic [COUNT_BITS-1:0]  snap_count_reg;
    logic [SAMPLE_BITS-1:0] snap_peak_reg;
    logic [BIN_W-1:0]       snap_bin_reg;

    logic [SAMPLE_BITS-1:0] mag_in;
    logic [SAMPLE_BITS-1:0] partial;
    logic [PROD_W-1:0]      prod_next;
    logic [SUM_W:0]         sum_ext;
    logic [SUM_W-1:0]       sum_next;
    logic [SAMPLE_BITS-1:0] peak_next;
    logic [COUNT_BITS-1:0]  count_next;
    logic [CMP_W-1:0]       limit;
    logic                   close_now;

    // Magnitude of the sample; the most negative code maps to full scale.
    assign mag_in = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample + 1'b1) : sample;

    // One multiplier bit per cycle, most significant bit first.
    assign partial   = mplr_reg[SAMPLE_BITS-1] ? mag_reg : '0;
    assign prod_next = {prod_reg[PROD_W-2:0], 1'b0} + {{SAMPLE_BITS{1'b0}}, partial};

    // Saturating sum of squares, peak and count update.
    assign sum_ext    = {1'b0, sum_reg} + (SUM_W + 1)'(prod_reg);
    assign sum_next   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    assign peak_next  = (mag_reg > peak_reg) ? mag_reg : peak_reg;
    assign count_next = count_reg + 1'b1;

    // A bin closes when full, at the counter limit or at end of stream.
    assign limit     = (samples_per_bin == '0) ? CMP_W'(1) : CMP_W'(samples_per_bin);
    assign close_now = eos_reg || (CMP_W'(count_next) >= limit) || (count_next == COUNT_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            close_reg <= '0;
            sum_reg   <= '0;
            peak_reg  <= '0;
            count_reg <= '0;
            bin_reg   <= '0;
        end else begin
            case (state_reg)
                A_IDLE: begin
                    close_reg <= '0;
                    if (start) begin
                        mag_reg   <= mag_in;
                        mplr_reg  <= mag_in;
                        prod_reg  <= '0;
                        step_reg  <= LAST_STEP;
                        eos_reg   <= eos;
                        state_reg <= A_SQUARE;
                    end
                end
                A_SQUARE: begin
                    close_reg <= '0;
                    prod_reg <= prod_next;
                    mplr_reg <= {mplr_reg[SAMPLE_BITS-2:0], 1'b0};
                    if (step_reg == '0) begin
                        state_reg <= A_UPDATE;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                A_UPDATE: begin
                    close_reg.valid     <= close_now;
                    close_reg.final_bin <= eos_reg;
                    if (close_now) begin
                        snap_sum_reg    <= sum_next;
                        snap_count_reg  <= count_next;
                        snap_peak_reg   <= peak_next;
                        snap_bin_reg    <= bin_reg;
                        sum_reg   <= '0;
                        peak_reg  <= '0;
                        count_reg <= '0;
                        bin_reg   <= eos_reg ? '0 : bin_reg + 1'b1;
                    end else begin
                        sum_reg   <= sum_next;
                        peak_reg  <= peak_next;
                        count_reg <= count_next;
                    end
                    state_reg <= A_IDLE;
                end
                default: begin
                    close_reg <= '0;
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != A_IDLE);
    assign close     = close_reg;
    assign bin_sum   = snap_sum_reg;
    assign bin_count = snap_count_reg;
    assign bin_peak  = snap_peak_reg;
    assign bin_index = snap_bin_reg;

endmodule

// File: sv/abprm_lvl.sv
module abprm_lvl #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 20,
    parameter int SUM_W       = 51
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  abprm_pkg::close_t           close,
    input  logic [SUM_W-1:0]            bin_sum,
    input  logic [COUNT_BITS-1:0]       bin_count,
    input  logic [SAMPLE_BITS-1:0]      bin_peak,
    input  logic [abprm_pkg::BIN_W-1:0] bin_index,
    input  logic                        take,
    output logic                        busy,
    output logic                        done,
    output abprm_pkg::result_t          result
);
    import abprm_pkg::*;

    localparam int N_W        = SUM_W + RMS_SCALE_W;
    localparam int FRAC_SHIFT = 2 * SAMPLE_BITS - 2;
    localparam int PK_W       = SAMPLE_BITS + LEVEL_W;
    localparam logic [PK_W-1:0] HALF_FS = PK_W'(1) << (SAMPLE_BITS - 2);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_ROOT,
        L_DONE
    } lvl_state_t;

    lvl_state_t            state_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [N_W-1:0]        nacc_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [QUO_W-1:0]      num_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [ROOT_W-1:0]     root_reg;
    result_t               res_reg;

    logic [N_W-1:0]        mul_add;
    logic [N_W-1:0]        nacc_next;
    logic [N_W-1:0]        scaled;
    logic [N_W-1:0]        scaled_hi;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;
    logic [COUNT_BITS-1:0] rem_next;
    logic [QUO_W-1:0]      quo_next;
    logic [ROOT_W-1:0]     cand;
    logic [2*ROOT_W-1:0]   cand_sq;
    logic [ROOT_W-1:0]     root_next;
    logic [ROOT_W:0]       rms_wide;
    logic [LEVEL_W-1:0]    rms_level;
    logic [PK_W-1:0]       pk_scaled;
    logic [LEVEL_W:0]      pk_top;
    logic [LEVEL_W-1:0]    peak_level;

    // Peak level: round(peak * 255 / FS), saturated.
    assign pk_scaled  = {bin_peak, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, bin_peak} + HALF_FS;
    assign pk_top     = pk_scaled[PK_W-1:SAMPLE_BITS-1];
    assign peak_level = pk_top[LEVEL_W] ? LEVEL_MAX : pk_top[LEVEL_W-1:0];

    // Shift-add multiply by the RMS scale, one constant bit per cycle.
    assign mul_add   = RMS_SCALE[step_reg] ? N_W'(sum_reg) : '0;
    assign nacc_next = {nacc_reg[N_W-2:0], 1'b0} + mul_add;

    // Drop the FS^2 fraction; the upper part is the first partial remainder.
    assign scaled    = nacc_next >> FRAC_SHIFT;
    assign scaled_hi = scaled >> QUO_W;

    // Restoring division by the sample count, one quotient bit per cycle.
    assign trial    = {rem_reg, num_reg[QUO_W-1]};
    assign fits     = (trial >= {1'b0, n_reg});
    assign diff     = trial - {1'b0, n_reg};
    assign rem_next = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
    assign quo_next = {quo_reg[QUO_W-2:0], fits};

    // Integer square root, one root bit per cycle.
    assign cand      = root_reg | (ROOT_W'(1) << step_reg[ROOT_STEP_W-1:0]);
    assign cand_sq   = {{ROOT_W{1'b0}}, cand} * {{ROOT_W{1'b0}}, cand};
    assign root_next = (cand_sq <= quo_reg) ? cand : root_reg;

    // Largest level k with (2k-1)^2 <= q.
    assign rms_wide  = ({1'b0, root_next} + 1'b1) >> 1;
    assign rms_level = (rms_wide > (ROOT_W + 1)'(LEVEL_MAX)) ? LEVEL_MAX
                                                             : rms_wide[LEVEL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            case (state_reg)
                L_IDLE: begin
                    if (close.valid) begin
                        sum_reg   <= bin_sum;
                        n_reg     <= bin_count;
                        nacc_reg  <= '0;
                        step_reg  <= STEP_W'(RMS_SCALE_W - 1);
                        res_reg.bin_number <= bin_index;
                        res_reg.peak_level <= peak_level;
                        res_reg.final_bin  <= close.final_bin;
                        state_reg <= L_MUL;
                    end
                end
                L_MUL: begin
                    nacc_reg <= nacc_next;
                    if (step_reg == '0) begin
                        rem_reg   <= scaled_hi[COUNT_BITS-1:0];
                        num_reg   <= scaled[QUO_W-1:0];
                        quo_reg   <= '0;
                        step_reg  <= STEP_W'(QUO_W - 1);
                        state_reg <= L_DIV;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                L_DIV: begin
                    rem_reg <= rem_next;
                    num_reg <= {num_reg[QUO_W-2:0], 1'b0};
                    quo_reg <= quo_next;
                    if (step_reg == '0) begin
                        root_reg  <= '0;
                        step_reg  <= STEP_W'(ROOT_W - 1);
                        state_reg <= L_ROOT;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                L_ROOT: begin
                    root_reg <= root_next;
                    if (step_reg == '0) begin
                        res_reg.rms_level <= rms_level;
                        state_reg <= L_DONE;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                L_DONE: begin
                    if (take) begin
                        state_reg <= L_IDLE;
                    end
                end
                default: begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != L_IDLE);
    assign done   = (state_reg == L_DONE);
    assign result = res_reg;

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import abprm_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W = 20;
    localparam int COUNT_LIMIT = (1 << COUNT_W) - 1;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_AFTER = 25;
    localparam int HOLD_CYCLES = 1200;
    localparam int STALL_LIMIT = 4000;
    localparam logic [APB_ADDR_W-1:0] BIN_SIZE_ADDR = {REG_SAMPLES_PER_BIN, 2'b00};

    typedef enum bit {
        ROW_SAMPLE,
        ROW_BIN_SIZE
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic [SPB_W-1:0]    bin_size;
        logic [SAMPLE_W-1:0] sample;
        bit                  end_of_stream;
        bit                  typed;
        result_t             level;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Level meter state as the block should hold it.
    logic [SPB_W-1:0]    bin_size;
    logic [63:0]         acc_square_sum;
    logic [SAMPLE_W:0]   acc_peak;
    int unsigned         acc_count;
    logic [BIN_W-1:0]    bin_index;

    result_t   pending_levels[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    bit        in_random = 1'b0;

    audio_bin_peak_rms_meter #(
        .SAMPLE_BITS(SAMPLE_W),
        .COUNT_BITS (COUNT_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
        end
    endtask

    // Appends one row to the directed table.
    function automatic void add_row(input stim_row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    // Peak level: magnitude scaled to 0..255, rounded half up, saturated.
    function automatic logic [LEVEL_W-1:0] peak_code(input logic [SAMPLE_W:0] mag);
        int unsigned scaled;
        scaled = (mag * 255 + (1 << (SAMPLE_W - 2))) >> (SAMPLE_W - 1);
        return (scaled > 255) ? LEVEL_MAX : scaled[LEVEL_W-1:0];
    endfunction

    // RMS level: the largest k with 4*255^2*sum >= (2k-1)^2 * FS^2 * n, exact in integers.
    function automatic logic [LEVEL_W-1:0] rms_code(input logic [63:0] sum,
                                                    input int unsigned n);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [LEVEL_W-1:0] code;
        code = '0;
        if (n == 0) begin
            return code;
        end
        lhs = sum;
        lhs = lhs * (4 * 255 * 255);
        for (int k = 1; k <= 255; k++) begin
            rhs = 2 * k - 1;
            rhs = rhs * rhs * n;
            rhs = rhs << (2 * (SAMPLE_W - 1));
            if (lhs < rhs) begin
                break;
            end
            code = LEVEL_W'(k);
        end
        return code;
    endfunction

    // Accumulates one sample and returns 1 with the levels when the bin closes.
    // The square sum cannot saturate at these sample and count widths.
    function automatic bit meter_accept_sample(input logic [SAMPLE_W-1:0] value,
                                               input bit eos, output result_t level);
        logic [SAMPLE_W:0] mag;
        int unsigned limit;
        mag = {1'b0, value};
        if (value[SAMPLE_W-1]) begin
            mag = {1'b1, {SAMPLE_W{1'b0}}} - mag;
        end
        acc_square_sum = acc_square_sum + mag * mag;
        if (mag > acc_peak) begin
            acc_peak = mag;
        end
        acc_count++;
        limit = (bin_size == 0) ? 1 : bin_size;
        level = '0;
        if (!eos && acc_count < limit && acc_count < COUNT_LIMIT) begin
            return 1'b0;
        end
        level.bin_number = bin_index;
        level.peak_level = peak_code(acc_peak);
        level.rms_level = rms_code(acc_square_sum, acc_count);
        level.final_bin = eos;
        acc_square_sum = '0;
        acc_peak = '0;
        acc_count = 0;
        bin_index = eos ? '0 : bin_index + 1'b1;
        return 1'b1;
    endfunction

    function automatic stim_row_t size_row(input logic [SPB_W-1:0] size);
        stim_row_t r;
        r.kind = ROW_BIN_SIZE;
        r.bin_size = size;
        r.sample = '0;
        r.end_of_stream = 1'b0;
        r.typed = 1'b0;
        r.level = '0;
        return r;
    endfunction

    function automatic stim_row_t sample_row(input logic [SAMPLE_W-1:0] value, input bit eos,
                                             input bit typed, input result_t level);
        stim_row_t r;
        r.kind = ROW_SAMPLE;
        r.bin_size = '0;
        r.sample = value;
        r.end_of_stream = eos;
        r.typed = typed;
        r.level = level;
        return r;
    endfunction

    // Offers one sample after a gap, waits for its transfer and records what it yields.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit eos,
                               input int unsigned gap, input bit typed, input result_t want);
        result_t level;
        if (gap != 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tlast <= eos;
        do @(posedge aclk); while (!s_tready);
        if (meter_accept_sample(value, eos, level)) begin
            pending_levels = {pending_levels, (typed ? want : level)};
        end
    endtask

    // Stops offering samples and lets the block drain completely.
    task automatic settle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Optional write of samples_per_bin, then a read that must return the held value.
    task automatic cfg_access(input bit do_write, input logic [SPB_W-1:0] value);
        if (do_write) begin
            @(negedge aclk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= BIN_SIZE_ADDR;
            pwdata <= {{(APB_DATA_W - SPB_W){1'b0}}, value};
            @(negedge aclk) penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            bin_size = value;
        end
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= BIN_SIZE_ADDR;
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {{(APB_DATA_W - SPB_W){1'b0}}, bin_size}) begin
            report_mismatch("samples_per_bin read", bin_size, prdata);
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Every result transfer is compared with the oldest pending expectation.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                report_mismatch("result with none pending", '0, {m_tlast, m_tdata});
            end else begin
                want = pending_levels.pop_front();
                if (m_tdata[BIN_W-1:0] !== want.bin_number)
                    report_mismatch("bin_number", want.bin_number, m_tdata[BIN_W-1:0]);
                if (m_tdata[BIN_W+LEVEL_W-1:BIN_W] !== want.peak_level)
                    report_mismatch("peak_level", want.peak_level,
                                    m_tdata[BIN_W+LEVEL_W-1:BIN_W]);
                if (m_tdata[BIN_W+2*LEVEL_W-1:BIN_W+LEVEL_W] !== want.rms_level)
                    report_mismatch("rms_level", want.rms_level,
                                    m_tdata[BIN_W+2*LEVEL_W-1:BIN_W+LEVEL_W]);
                if (m_tlast !== want.final_bin)
                    report_mismatch("final_bin", want.final_bin, m_tlast);
            end
        end
    end

    // Watchdog: too long without any transfer on any port ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, steady stretches, and one long hold-off that backs up
    // the block while samples are still being offered.
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        bit hold_done;
        taken = 0;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = ((taken % 64) >= 48) ? 0 : $urandom_range(0, 8);
            if (!hold_done && in_random && s_tvalid && taken >= HOLD_AFTER) begin
                stall = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall != 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Sample side: directed table first, then random phases of bin sizes.
    initial begin : stimulus
        stim_row_t row;
        logic [SPB_W-1:0] size;
        logic [SAMPLE_W-1:0] value;
        int unsigned phase_items;
        int unsigned sel;
        int unsigned sent_random;
        bit eos;
        bit no_gap;
        bit big;

        bin_size = SPB_RESET;
        acc_square_sum = '0;
        acc_peak = '0;
        acc_count = 0;
        bin_index = '0;
        sent_random = 0;

        // Partial bin at the reset bin size, closed by end of stream.
        add_row(sample_row(16'd1000, 1'b0, 1'b0, '0));
        add_row(sample_row(-16'sd1000, 1'b0, 1'b0, '0));
        add_row(sample_row(16'd0, 1'b1, 1'b0, '0));
        // One sample per bin: extremes, the rounding edge at 64/65, restart after end of stream.
        add_row(size_row(20'd1));
        add_row(sample_row(16'h7FFF, 1'b0, 1'b1, '{24'd0, 8'd255, 8'd255, 1'b0}));
        add_row(sample_row(16'h8000, 1'b0, 1'b1, '{24'd1, 8'd255, 8'd255, 1'b0}));
        add_row(sample_row(16'h0000, 1'b0, 1'b1, '{24'd2, 8'd0, 8'd0, 1'b0}));
        add_row(sample_row(16'd64, 1'b0, 1'b1, '{24'd3, 8'd0, 8'd0, 1'b0}));
        add_row(sample_row(16'd65, 1'b0, 1'b1, '{24'd4, 8'd1, 8'd1, 1'b0}));
        add_row(sample_row(-16'sd65, 1'b1, 1'b1, '{24'd5, 8'd1, 8'd1, 1'b1}));
        add_row(sample_row(16'd1, 1'b0, 1'b1, '{24'd0, 8'd0, 8'd0, 1'b0}));
        // A bin size of zero behaves as one; half scale rounds up to 128.
        add_row(size_row(20'd0));
        add_row(sample_row(16'hFFFF, 1'b0, 1'b1, '{24'd1, 8'd0, 8'd0, 1'b0}));
        add_row(sample_row(16'd16384, 1'b1, 1'b1, '{24'd2, 8'd128, 8'd128, 1'b1}));
        // End of stream on a full bin, then on a partial one.
        add_row(size_row(20'd3));
        add_row(sample_row(16'd100, 1'b0, 1'b0, '0));
        add_row(sample_row(-16'sd200, 1'b0, 1'b0, '0));
        add_row(sample_row(16'd300, 1'b1, 1'b0, '0));
        add_row(sample_row(16'd7, 1'b0, 1'b0, '0));
        add_row(sample_row(16'h8000, 1'b1, 1'b0, '0));
        // Largest bin size, which also equals the counter limit at these widths.
        add_row(size_row(20'hFFFFF));
        add_row(sample_row(16'h7FFF, 1'b0, 1'b0, '0));
        add_row(sample_row(16'h8001, 1'b0, 1'b0, '0));
        add_row(sample_row(16'd12345, 1'b1, 1'b0, '0));

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        cfg_access(1'b0, '0);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_BIN_SIZE) begin
                settle();
                cfg_access(1'b1, row.bin_size);
            end else begin
                send_sample(row.sample, row.end_of_stream, $urandom_range(0, 8),
                            row.typed, row.level);
            end
        end

        // Random phases: mostly short bins, now and then long or degenerate ones.
        in_random = 1'b1;
        while (sent_random < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            big = 1'b0;
            if (sel == 0) begin
                size = '0;
            end else if (sel == 1) begin
                size = 20'd1;
            end else if (sel == 2) begin
                size = SPB_W'($urandom_range(100, 300));
            end else if (sel == 3) begin
                size = 20'hFFFFF;
                big = 1'b1;
            end else begin
                size = SPB_W'($urandom_range(2, 24));
            end
            phase_items = big ? $urandom_range(4, 16) : $urandom_range(20, 120);
            no_gap = ($urandom_range(0, 3) == 0);
            settle();
            cfg_access(1'b1, size);
            for (int n = 0; n < phase_items; n++) begin
                sel = $urandom_range(0, 7);
                if (sel == 0) begin
                    case ($urandom_range(0, 4))
                        0: value = 16'h7FFF;
                        1: value = 16'h8000;
                        2: value = 16'h0000;
                        3: value = 16'hFFFF;
                        default: value = 16'h0001;
                    endcase
                end else if (sel <= 2) begin
                    value = SAMPLE_W'($urandom_range(0, 600) - 300);
                end else begin
                    value = SAMPLE_W'($urandom);
                end
                eos = ($urandom_range(0, 39) == 0) || (big && n == phase_items - 1);
                send_sample(value, eos, no_gap ? 0 : $urandom_range(0, 8), 1'b0, '0);
                sent_random++;
            end
        end
        in_random = 1'b0;

        // Close the last stream so its partial bin is checked as well.
        send_sample(SAMPLE_W'($urandom), 1'b1, $urandom_range(0, 8), 1'b0, '0);
        settle();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
